FILE: hdl/tlc_pkg.sv
// ============================================================================
// tlc_pkg
// Shared types, register codes and helpers of the traffic light controller.
// ============================================================================
package tlc_pkg;

  localparam int unsigned CountW  = 7;
  localparam int unsigned SwapW   = 4;
  localparam int unsigned DigitW  = 4;
  localparam int unsigned PaddrW  = 4;
  localparam int unsigned PdataW  = 32;
  localparam int unsigned MaxCount = 99;

  // Register index, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_SOUTH_TIME   = 2'd0,
    REG_WEST_TIME    = 2'd1,
    REG_YELLOW_THR   = 2'd2,
    REG_MAN_YELLOW   = 2'd3
  } reg_idx_e;

  // Lamp set, west red in the least significant bit.
  typedef struct packed {
    logic south_red;
    logic south_yellow;
    logic south_green;
    logic west_green;
    logic west_yellow;
    logic west_red;
  } lamps_t;

  localparam lamps_t LampsOff     = '{default: 1'b0};
  localparam lamps_t LampsSouthGo = '{south_green: 1'b1, west_red: 1'b1, default: 1'b0};
  localparam lamps_t LampsSouthYl = '{south_yellow: 1'b1, west_red: 1'b1, default: 1'b0};
  localparam lamps_t LampsWestGo  = '{west_green: 1'b1, south_red: 1'b1, default: 1'b0};
  localparam lamps_t LampsWestYl  = '{west_yellow: 1'b1, south_red: 1'b1, default: 1'b0};

  typedef struct packed {
    logic [CountW-1:0] south_time;
    logic [CountW-1:0] west_time;
    logic [CountW-1:0] yellow_thr;
    logic [SwapW-1:0]  man_yellow;
  } cfg_t;

  // What one tick leaves for the output stage.
  typedef struct packed {
    lamps_t            lamps;
    logic [CountW-1:0] shown;
  } res_t;

  // Phase start count: zero runs as one, anything past 99 as 99.
  function automatic logic [CountW-1:0] load_count(input logic [CountW-1:0] t);
    logic [CountW-1:0] r;
    if (t == '0) begin
      r = CountW'(1);
    end else if (t > CountW'(MaxCount)) begin
      r = CountW'(MaxCount);
    end else begin
      r = t;
    end
    return r;
  endfunction

endpackage

FILE: hdl/tlc_cfg.sv
// ============================================================================
// tlc_cfg
// APB register file holding the phase times and yellow settings.
// ============================================================================
module tlc_cfg import tlc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_SOUTH_TIME: cfg_d.south_time = pwdata[CountW-1:0];
        REG_WEST_TIME:  cfg_d.west_time  = pwdata[CountW-1:0];
        REG_YELLOW_THR: cfg_d.yellow_thr = pwdata[CountW-1:0];
        REG_MAN_YELLOW: cfg_d.man_yellow = pwdata[SwapW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SOUTH_TIME: prdata = PdataW'(cfg_q.south_time);
      REG_WEST_TIME:  prdata = PdataW'(cfg_q.west_time);
      REG_YELLOW_THR: prdata = PdataW'(cfg_q.yellow_thr);
      REG_MAN_YELLOW: prdata = PdataW'(cfg_q.man_yellow);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.south_time <= CountW'(15);
      cfg_q.west_time  <= CountW'(23);
      cfg_q.yellow_thr <= CountW'(3);
      cfg_q.man_yellow <= SwapW'(3);
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: hdl/tlc_core.sv
// ============================================================================
// tlc_core
// Controller state and the one-tick update of phases, swaps and lamps.
// ============================================================================
module tlc_core import tlc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic step_i,
  input  logic auto_mode_i,
  input  logic manual_request_n_i,
  input  logic start_n_i,
  output res_t res_o
);

  logic              running_q, running_d;
  logic              auto_active_q, auto_active_d;
  logic              west_phase_q, west_phase_d;
  logic              swap_to_west_q, swap_to_west_d;
  logic [CountW-1:0] phase_count_q, phase_count_d;
  logic [CountW-1:0] shown_q, shown_d;
  logic [SwapW-1:0]  swap_timer_q, swap_timer_d;
  lamps_t            lamps_q, lamps_d;
  logic [SwapW-1:0]  swap_len;

  assign swap_len = (cfg_i.man_yellow == '0) ? SwapW'(1) : cfg_i.man_yellow;

  always_comb begin
    running_d      = running_q;
    auto_active_d  = auto_active_q;
    west_phase_d   = west_phase_q;
    swap_to_west_d = swap_to_west_q;
    phase_count_d  = phase_count_q;
    shown_d        = shown_q;
    swap_timer_d   = swap_timer_q;
    lamps_d        = lamps_q;
    if (step_i) begin
      running_d = running_q || !start_n_i;
      if (running_d) begin
        if (swap_timer_q != '0) begin
          swap_timer_d = swap_timer_q - SwapW'(1);
          if (swap_timer_d == '0) begin
            lamps_d = swap_to_west_q ? LampsWestGo : LampsSouthGo;
          end
        end else if (auto_mode_i) begin
          if (!auto_active_q) begin
            auto_active_d = 1'b1;
            west_phase_d  = 1'b0;
            phase_count_d = load_count(cfg_i.south_time);
          end else if (phase_count_q <= CountW'(1)) begin
            west_phase_d  = !west_phase_q;
            phase_count_d = load_count(west_phase_d ? cfg_i.west_time : cfg_i.south_time);
          end else begin
            phase_count_d = phase_count_q - CountW'(1);
          end
          if (phase_count_d > cfg_i.yellow_thr) begin
            lamps_d = west_phase_d ? LampsWestGo : LampsSouthGo;
          end else begin
            lamps_d = west_phase_d ? LampsWestYl : LampsSouthYl;
          end
          shown_d = phase_count_d;
        end else begin
          auto_active_d = 1'b0;
          shown_d       = '0;
          if (!manual_request_n_i) begin
            // west has priority if both somehow show
            if (lamps_q.west_green || lamps_q.west_yellow) begin
              lamps_d        = LampsWestYl;
              swap_to_west_d = 1'b0;
              swap_timer_d   = swap_len;
            end else if (lamps_q.south_green || lamps_q.south_yellow) begin
              lamps_d        = LampsSouthYl;
              swap_to_west_d = 1'b1;
              swap_timer_d   = swap_len;
            end
          end
        end
      end
    end
  end

  assign res_o.lamps = lamps_d;
  assign res_o.shown = shown_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q      <= 1'b0;
      auto_active_q  <= 1'b0;
      west_phase_q   <= 1'b0;
      swap_to_west_q <= 1'b0;
      phase_count_q  <= '0;
      shown_q        <= '0;
      swap_timer_q   <= '0;
      lamps_q        <= LampsOff;
    end else begin
      running_q      <= running_d;
      auto_active_q  <= auto_active_d;
      west_phase_q   <= west_phase_d;
      swap_to_west_q <= swap_to_west_d;
      phase_count_q  <= phase_count_d;
      shown_q        <= shown_d;
      swap_timer_q   <= swap_timer_d;
      lamps_q        <= lamps_d;
    end
  end

  a_no_double_green: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(lamps_q.west_green && lamps_q.south_green))
    else $error("both directions green");

  a_running_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q |=> running_q)
    else $error("controller stopped after start");

  a_shown_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shown_q <= CountW'(MaxCount))
    else $error("shown count above 99");

  a_dark_until_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !running_q |-> (lamps_q == LampsOff && swap_timer_q == '0))
    else $error("activity before start");

  a_swap_shows_yellow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (swap_timer_q != '0) |-> (lamps_q.west_yellow || lamps_q.south_yellow))
    else $error("swap pending without yellow lamp");

endmodule

FILE: hdl/tlc_out.sv
// ============================================================================
// tlc_out
// Result register: lamp outputs and BCD split of the shown count.
// ============================================================================
module tlc_out import tlc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  res_t              res_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output lamps_t            lamps_o,
  output logic [DigitW-1:0] tens_o,
  output logic [DigitW-1:0] ones_o
);

  logic              valid_q, valid_d;
  lamps_t            lamps_q;
  logic [DigitW-1:0] tens_q, ones_q;
  logic [DigitW-1:0] tens_d, ones_d;
  logic [14:0]       prod;
  logic [CountW-1:0] rem;

  // x*205 >> 11 is x/10 for every 7-bit x (0..127)
  assign prod   = 15'(res_i.shown) * 15'd205;
  assign tens_d = prod[14:11];
  assign rem    = res_i.shown - CountW'(tens_d) * CountW'(10);
  assign ones_d = rem[DigitW-1:0];

  assign valid_d = load_i ? 1'b1 : (out_ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      lamps_q <= res_i.lamps;
      tens_q  <= tens_d;
      ones_q  <= ones_d;
    end
  end

  assign out_valid_o = valid_q;
  assign lamps_o     = lamps_q;
  assign tens_o      = tens_q;
  assign ones_o      = ones_q;

endmodule

FILE: hdl/two_way_traffic_light_controller.sv
// ============================================================================
// two_way_traffic_light_controller
// Two-way intersection lights stepped by one input item per tick.
// ============================================================================
// Each input item is one tick (normally one second). The controller stays dark
// with 00 on the display until start_n reads low, then runs for good. In
// automatic mode it counts the south phase down from south_time, then the west
// phase from west_time, showing yellow once the count reaches yellow_threshold;
// in manual mode a low request yellows the moving direction for
// manual_yellow_time ticks and swaps right of way. Rate: one item per clock.
// The whole tick update is a single pass of logic from the state registers to
// the result register, so the result item appears the cycle after its input
// item is taken. The result register is the only buffer: an item is taken
// whenever that register is empty or is being emptied in the same cycle, so a
// stalled output stalls the input. Registers sit on an APB port at byte
// addresses 0, 4, 8 and 12; write them only while the block is idle.
module two_way_traffic_light_controller import tlc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  // tick items in
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              auto_mode_i,
  input  logic              manual_request_n_i,
  input  logic              start_n_i,
  // result items out
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              west_red_o,
  output logic              west_yellow_o,
  output logic              west_green_o,
  output logic              south_green_o,
  output logic              south_yellow_o,
  output logic              south_red_o,
  output logic [DigitW-1:0] display_tens_o,
  output logic [DigitW-1:0] display_ones_o
);

  cfg_t   cfg;
  res_t   res;
  lamps_t lamps;
  logic   accept;

  // Result register empty, or emptying this cycle.
  assign in_ready_o = !out_valid_o || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  tlc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // State update happens only on an accepted tick.
  tlc_core u_core (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg),
    .step_i             (accept),
    .auto_mode_i        (auto_mode_i),
    .manual_request_n_i (manual_request_n_i),
    .start_n_i          (start_n_i),
    .res_o              (res)
  );

  tlc_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .res_i       (res),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .lamps_o     (lamps),
    .tens_o      (display_tens_o),
    .ones_o      (display_ones_o)
  );

  assign west_red_o     = lamps.west_red;
  assign west_yellow_o  = lamps.west_yellow;
  assign west_green_o   = lamps.west_green;
  assign south_green_o  = lamps.south_green;
  assign south_yellow_o = lamps.south_yellow;
  assign south_red_o    = lamps.south_red;

endmodule

FILE: tb/sv/tb.sv
// ============================================================================
// tb
// Self-checking bench for the two-way traffic light controller.
// ============================================================================
// Each tick item is sent on the valid/ready input channel. A scoreboard class
// predicts the lamps and BCD display of every tick. Each result item is then
// checked against the oldest prediction. The run has a short directed part:
// start-up, dark lamps, both manual swap directions and entry to automatic.
// Then four register phases run random mode/request/start ticks, two of them
// at the register extremes. Sender bursts, receiver stall patterns and one
// long receiver hold-off keep the single result register busy.
// ============================================================================
module tb;
  import tlc_pkg::*;

  localparam int unsigned HalfPeriod    = 4;
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned HoldOffCycles = 60;
  localparam int unsigned TicksPerPhase = 130;
  localparam int unsigned LimitCycles   = 300000;
  localparam int unsigned ReportMax     = 10;

  // What one result item shows: six lamps and two BCD digits.
  typedef struct packed {
    lamps_t            lamps;
    logic [DigitW-1:0] tens;
    logic [DigitW-1:0] ones;
  } light_view_t;

  // Receiver ready patterns.
  typedef enum int unsigned {
    RX_OPEN,
    RX_HALF,
    RX_SPARSE,
    RX_TOGGLE
  } rx_pattern_e;

  // --------------------------------------------------------------------------
  // Scoreboard: a tick-level copy of the controller plus the queue of views
  // it has predicted but not yet seen on the output.
  // --------------------------------------------------------------------------
  class light_scoreboard;
    logic [CountW-1:0] south_time, west_time, yellow_thr;
    logic [SwapW-1:0]  man_yellow;
    bit                running, auto_on, west_turn, swap_west;
    logic [CountW-1:0] phase_cnt, shown;
    logic [SwapW-1:0]  swap_left;
    lamps_t            lamps;
    light_view_t       pending_q[$];
    int unsigned       mismatches;

    function new();
      south_time = CountW'(15);
      west_time  = CountW'(23);
      yellow_thr = CountW'(3);
      man_yellow = SwapW'(3);
      running    = 1'b0;
      auto_on    = 1'b0;
      west_turn  = 1'b0;
      swap_west  = 1'b0;
      phase_cnt  = '0;
      shown      = '0;
      swap_left  = '0;
      lamps      = LampsOff;
      mismatches = 0;
    endfunction

    // Zero starts a phase at one, anything above 99 at 99.
    function logic [CountW-1:0] start_count(input logic [CountW-1:0] t);
      if (t == '0) return CountW'(1);
      return (t > CountW'(MaxCount)) ? CountW'(MaxCount) : t;
    endfunction

    function void write_reg(input reg_idx_e idx, input logic [PdataW-1:0] v);
      case (idx)
        REG_SOUTH_TIME: south_time = v[CountW-1:0];
        REG_WEST_TIME:  west_time  = v[CountW-1:0];
        REG_YELLOW_THR: yellow_thr = v[CountW-1:0];
        REG_MAN_YELLOW: man_yellow = v[SwapW-1:0];
        default: ;
      endcase
    endfunction

    function void note_tick(input logic auto_m, input logic req_n, input logic start_n);
      logic [SwapW-1:0] yl_ticks;
      light_view_t      v;
      yl_ticks = (man_yellow == '0) ? SwapW'(1) : man_yellow;
      if (!running && !start_n) running = 1'b1;
      if (running) begin
        if (swap_left != '0) begin
          swap_left--;
          if (swap_left == '0) lamps = swap_west ? LampsWestGo : LampsSouthGo;
        end else if (auto_m) begin
          if (!auto_on) begin
            auto_on   = 1'b1;
            west_turn = 1'b0;
            phase_cnt = start_count(south_time);
          end else if (phase_cnt <= CountW'(1)) begin
            west_turn = !west_turn;
            phase_cnt = start_count(west_turn ? west_time : south_time);
          end else begin
            phase_cnt--;
          end
          if (west_turn) lamps = (phase_cnt > yellow_thr) ? LampsWestGo : LampsWestYl;
          else           lamps = (phase_cnt > yellow_thr) ? LampsSouthGo : LampsSouthYl;
          shown = phase_cnt;
        end else begin
          auto_on = 1'b0;
          shown   = '0;
          if (!req_n) begin
            // west wins if both were ever lit
            if (lamps.west_green || lamps.west_yellow) begin
              lamps     = LampsWestYl;
              swap_west = 1'b0;
              swap_left = yl_ticks;
            end else if (lamps.south_green || lamps.south_yellow) begin
              lamps     = LampsSouthYl;
              swap_west = 1'b1;
              swap_left = yl_ticks;
            end
          end
        end
      end
      v.lamps = lamps;
      v.tens  = DigitW'(shown / 10);
      v.ones  = DigitW'(shown % 10);
      pending_q.push_back(v);
    endfunction

    function void check_result(input light_view_t got);
      light_view_t want;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display("[%0t] result with no tick pending: lamps=%b digits=%0d%0d",
                   $realtime, got.lamps, got.tens, got.ones);
        return;
      end
      want = pending_q.pop_front();
      if (got.lamps !== want.lamps || got.tens !== want.tens || got.ones !== want.ones) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display("[%0t] mismatch: lamps exp=%b got=%b  digits exp=%0d%0d got=%0d%0d",
                   $realtime, want.lamps, got.lamps, want.tens, want.ones,
                   got.tens, got.ones);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic              clk_i;
  logic              rst_ni;
  logic              psel, penable, pwrite;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata;
  logic [PdataW-1:0] prdata;
  logic              pready;
  logic              in_valid_i, in_ready_o;
  logic              auto_mode_i, manual_request_n_i, start_n_i;
  logic              out_valid_o, out_ready_i;
  logic              west_red_o, west_yellow_o, west_green_o;
  logic              south_green_o, south_yellow_o, south_red_o;
  logic [DigitW-1:0] display_tens_o, display_ones_o;

  light_scoreboard lights_sb = new();
  bit              hold_off_req = 1'b0;   // set once by stimulus
  int unsigned     cycle_cnt = 0;

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #HalfPeriod clk_i = ~clk_i;
  end

  two_way_traffic_light_controller u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .auto_mode_i        (auto_mode_i),
    .manual_request_n_i (manual_request_n_i),
    .start_n_i          (start_n_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .west_red_o         (west_red_o),
    .west_yellow_o      (west_yellow_o),
    .west_green_o       (west_green_o),
    .south_green_o      (south_green_o),
    .south_yellow_o     (south_yellow_o),
    .south_red_o        (south_red_o),
    .display_tens_o     (display_tens_o),
    .display_ones_o     (display_ones_o)
  );

  // --------------------------------------------------------------------------
  // Watchdog: a hung handshake ends the run here.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LimitCycles) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: pre-edge values of both handshakes. The result check goes first;
  // a tick taken at this edge cannot have its result out at the same edge.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch
    light_view_t got;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got.lamps = {south_red_o, south_yellow_o, south_green_o,
                     west_green_o, west_yellow_o, west_red_o};
        got.tens  = display_tens_o;
        got.ones  = display_ones_o;
        lights_sb.check_result(got);
      end
      if (in_valid_i && in_ready_o)
        lights_sb.note_tick(auto_mode_i, manual_request_n_i, start_n_i);
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: ready follows a random pattern that is redrawn after a random run.
  // On request it drops ready for a long stretch so the result register
  // fills and the input stalls while the sender keeps offering.
  // --------------------------------------------------------------------------
  initial begin : receiver
    rx_pattern_e pattern;
    int unsigned left;
    logic        rdy;
    bit          held;
    pattern     = RX_OPEN;
    left        = 0;
    held        = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req && !held) begin
        out_ready_i <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        held = 1'b1;
      end else begin
        if (left == 0) begin
          pattern = rx_pattern_e'($urandom_range(0, 3));
          left    = $urandom_range(20, 120);
        end
        left--;
        case (pattern)
          RX_OPEN:   rdy = 1'b1;
          RX_HALF:   rdy = 1'($urandom_range(0, 1));
          RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
          default:   rdy = left[0];
        endcase
        out_ready_i <= rdy;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------

  // Offer one tick and hold it until it is taken.
  task automatic send_tick(input logic auto_m, input logic req_n, input logic start_n);
    in_valid_i         <= 1'b1;
    auto_mode_i        <= auto_m;
    manual_request_n_i <= req_n;
    start_n_i          <= start_n;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Stop sending and wait until every predicted view has come out.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (lights_sb.pending_q.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // APB write: setup cycle, access cycle, then the bus returns to idle; pready is
  // always high.
  task automatic apb_write(input reg_idx_e idx, input logic [PdataW-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PaddrW'({idx, 2'b00});
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    lights_sb.write_reg(idx, v);
    @(posedge clk_i);
  endtask

  // Random ticks: mostly long automatic runs broken by short manual stretches
  // with swap requests, plus the odd single-tick mode glitch. Sent in bursts.
  task automatic run_ticks(input int unsigned n, input int hold_at);
    int unsigned mode_left, burst_left, gap;
    bit          manual;
    logic        a, r, s;
    mode_left  = 0;
    burst_left = $urandom_range(1, 30);
    manual     = 1'b0;
    for (int unsigned i = 0; i < n; i++) begin
      if (mode_left == 0) begin
        manual    = ($urandom_range(0, 9) < 3);
        mode_left = manual ? $urandom_range(1, 8) : $urandom_range(2, 40);
      end
      mode_left--;
      a = !manual;
      if ($urandom_range(0, 19) == 0) a = ~a;
      r = manual ? ($urandom_range(0, 2) != 0) : 1'($urandom_range(0, 1));
      s = 1'($urandom_range(0, 1));
      if (int'(i) == hold_at) hold_off_req = 1'b1;
      send_tick(a, r, s);
      burst_left--;
      if (burst_left == 0) begin
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        burst_left = $urandom_range(1, 30);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [PdataW-1:0] v_south, v_west, v_thr, v_man;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    in_valid_i         = 1'b0;
    auto_mode_i        = 1'b0;
    manual_request_n_i = 1'b1;
    start_n_i          = 1'b1;
    rst_ni             = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset register values (15/23/3/3).
    send_tick(1'b1, 1'b1, 1'b1);        // not started: dark, 00
    send_tick(1'b0, 1'b0, 1'b1);        // request before start does nothing
    send_tick(1'b0, 1'b1, 1'b0);        // start in manual: still dark
    send_tick(1'b0, 1'b0, 1'b1);        // request with dark lamps ignored
    repeat (5) send_tick(1'b1, 1'b1, 1'b1);   // enter auto, south 15..11
    send_tick(1'b0, 1'b0, 1'b1);        // swap south -> west starts
    send_tick(1'b1, 1'b0, 1'b1);        // swap ignores mode and requests
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1);        // last swap tick: west go
    send_tick(1'b0, 1'b1, 1'b1);        // manual hold
    send_tick(1'b0, 1'b0, 1'b1);        // swap west -> south starts
    repeat (3) send_tick(1'b0, 1'b1, 1'b0);   // start_n ignored once running
    repeat (3) send_tick(1'b1, 1'b0, 1'b1);   // back to auto, south reloads
    drain();

    // Register phases: low extremes, high extremes, then two random ones.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          v_south = 32'd0;  v_west = 32'd2;  v_thr = 32'd0;   v_man = 32'd0;
        end
        1: begin
          v_south = 32'd127; v_west = 32'd99; v_thr = 32'd127; v_man = 32'd15;
        end
        default: begin
          // junk in the unused upper bits must be dropped
          v_south = $urandom; v_south[CountW-1:0] = CountW'($urandom_range(1, 12));
          v_west  = $urandom; v_west[CountW-1:0]  = CountW'($urandom_range(1, 12));
          v_thr   = $urandom; v_thr[CountW-1:0]   = CountW'($urandom_range(0, 6));
          v_man   = $urandom; v_man[SwapW-1:0]    = SwapW'($urandom_range(1, 4));
        end
      endcase
      apb_write(REG_SOUTH_TIME, v_south);
      apb_write(REG_WEST_TIME,  v_west);
      apb_write(REG_YELLOW_THR, v_thr);
      apb_write(REG_MAN_YELLOW, v_man);
      run_ticks(TicksPerPhase, (p == 2) ? 60 : -1);
      drain();
    end

    if (lights_sb.mismatches == 0 && lights_sb.pending_q.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
